// ----- src/gdda_pkg.sv -----
// Shared widths, operation codes and controller/datapath command types for the date block.
package gdda_pkg;

   // Field widths of the request and response transactions
   localparam int OP_W     = 2;
   localparam int DAY_W    = 5;
   localparam int MONTH_W  = 4;
   localparam int YEAR_W   = 14;
   localparam int DELTA_W  = 23;
   localparam int SERIAL_W = 22;
   localparam int DIFF_W   = 23;

   // Default top year of the representable range
   localparam int unsigned MAX_YEAR_DEF = 9999;

   // Operation codes carried in the op field
   localparam logic [OP_W-1:0] OP_LOAD    = 2'd0;
   localparam logic [OP_W-1:0] OP_SHIFT   = 2'd1;
   localparam logic [OP_W-1:0] OP_COMPARE = 2'd2;

   // Commands from the controller to the datapath
   typedef enum logic [4:0] {
      CMD_NOP,
      CMD_CAPTURE,
      CMD_LOAD,
      CMD_SER1,
      CMD_SER2,
      CMD_SER3,
      CMD_SER4,
      CMD_SAVE_B,
      CMD_CLAMP,
      CMD_DIV400,
      CMD_CENT,
      CMD_GFIRST,
      CMD_GDIV,
      CMD_YEAR,
      CMD_MONTH,
      CMD_STORE,
      CMD_OUTLOAD
   } gdda_cmd_code_type;

   typedef struct packed {
      gdda_cmd_code_type code;
      logic              src_given;   // serial conversion works on the given date
   } gdda_cmd_type;

   // Status from the datapath to the controller
   typedef struct packed {
      logic [OP_W-1:0] op;
      logic            bit_last;     // division step at bit zero
      logic            cent_fit;     // another century fits in the remainder
      logic            year_fit;     // another year fits in the remainder
      logic            month_fit;    // another month fits in the remainder
   } gdda_status_type;

endpackage

// ----- src/gdda_req_if.sv -----
// Request channel: operation, date operand and day delta with valid/ready handshake.
interface gdda_req_if import gdda_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic [OP_W-1:0]           op;
   logic [DAY_W-1:0]          date_day;
   logic [MONTH_W-1:0]        date_month;
   logic [YEAR_W-1:0]         date_year;
   logic signed [DELTA_W-1:0] delta;

   modport source (output valid, op, date_day, date_month, date_year, delta, input ready);
   modport sink   (input valid, op, date_day, date_month, date_year, delta, output ready);
endinterface

// ----- src/gdda_rsp_if.sv -----
// Response channel: current date, serial day, comparison results and clip flag.
interface gdda_rsp_if import gdda_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic [DAY_W-1:0]         out_day;
   logic [MONTH_W-1:0]       out_month;
   logic [YEAR_W-1:0]        out_year;
   logic [SERIAL_W-1:0]      serial_day;
   logic signed [DIFF_W-1:0] day_difference;
   logic                     is_less;
   logic                     is_greater;
   logic                     is_equal;
   logic                     clipped;

   modport source (output valid, out_day, out_month, out_year, serial_day, day_difference,
                   is_less, is_greater, is_equal, clipped, input ready);
   modport sink   (input valid, out_day, out_month, out_year, serial_day, day_difference,
                   is_less, is_greater, is_equal, clipped, output ready);
endinterface

// ----- src/gregorian_date_day_arithmetic_top.sv -----
// Top level of the Gregorian date day arithmetic block.
// Keeps a current date (reset 1.1.0) and serves one request at a time: load a date, shift the
// current date by a signed day count, or compare it with a given date; every request returns
// one response with the current date and its serial day (1 is 1 January of year 0). A shift
// saturates at 1.1.0 or 31.12.MAX_YEAR and sets clipped. Each serial conversion takes four
// steps with reciprocal divides by 25, and the inverse conversion runs an 8-step division by
// the 400-year cycle, up to 4 century steps, a 6-step 4-year-group division, up to 4 year
// steps and up to 12 month steps in one subtract unit. A new request is accepted while the
// previous response still waits in its output register.
module gregorian_date_day_arithmetic_top import gdda_pkg::*; #(
   parameter int unsigned MAX_YEAR = MAX_YEAR_DEF
) (
   input logic        clock,
   input logic        reset,
   gdda_req_if.sink   req_chan,
   gdda_rsp_if.source rsp_chan
);

   gdda_cmd_type    cmd;
   gdda_status_type status;

   // Sequence the operation steps
   gdda_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   // Hold the date and do the arithmetic
   gdda_datapath #(
      .MAX_YEAR (MAX_YEAR)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .status      (status),
      .req_op      (req_chan.op),
      .req_day     (req_chan.date_day),
      .req_month   (req_chan.date_month),
      .req_year    (req_chan.date_year),
      .req_delta   (req_chan.delta),
      .rsp_day     (rsp_chan.out_day),
      .rsp_month   (rsp_chan.out_month),
      .rsp_year    (rsp_chan.out_year),
      .rsp_serial  (rsp_chan.serial_day),
      .rsp_diff    (rsp_chan.day_difference),
      .rsp_less    (rsp_chan.is_less),
      .rsp_greater (rsp_chan.is_greater),
      .rsp_equal   (rsp_chan.is_equal),
      .rsp_clipped (rsp_chan.clipped)
   );

endmodule

// ----- src/gdda_datapath.sv -----
// Datapath: current date, serial conversion steps, date reconstruction and response registers.
module gdda_datapath import gdda_pkg::*; #(
   parameter int unsigned MAX_YEAR = MAX_YEAR_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  gdda_cmd_type              cmd,
   output gdda_status_type           status,
   input  logic [OP_W-1:0]           req_op,
   input  logic [DAY_W-1:0]          req_day,
   input  logic [MONTH_W-1:0]        req_month,
   input  logic [YEAR_W-1:0]         req_year,
   input  logic signed [DELTA_W-1:0] req_delta,
   output logic [DAY_W-1:0]          rsp_day,
   output logic [MONTH_W-1:0]        rsp_month,
   output logic [YEAR_W-1:0]         rsp_year,
   output logic [SERIAL_W-1:0]       rsp_serial,
   output logic signed [DIFF_W-1:0]  rsp_diff,
   output logic                      rsp_less,
   output logic                      rsp_greater,
   output logic                      rsp_equal,
   output logic                      rsp_clipped
);

   // Serial accumulator, signed shift sum and remainder widths
   localparam int ACC_W  = 23;
   localparam int T_W    = 26;
   localparam int N_W    = 25;
   localparam int Q_W    = 8;
   localparam int YACC_W = 17;

   localparam int unsigned CYCLE_DAYS = 146097;
   localparam int unsigned TOP_Y      = MAX_YEAR + 1;
   localparam int unsigned TOP_I      = 365 * TOP_Y + (TOP_Y + 3) / 4 - (TOP_Y + 99) / 100
                                        + (TOP_Y + 399) / 400;
   localparam logic signed [T_W-1:0] TOP_SERIAL = T_W'(TOP_I);

   // Floor division by 25 through a reciprocal, exact below 8192
   function automatic logic [8:0] div25(input logic [12:0] v);
      logic [25:0] p;
      p = 26'(v) * 26'(13'd5243);
      return p[25:17];
   endfunction

   // Days in the months before month m of a common year
   function automatic logic [8:0] days_before_month(input logic [3:0] m);
      logic [8:0] d;
      case (m)
         4'd2:    d = 9'd31;
         4'd3:    d = 9'd59;
         4'd4:    d = 9'd90;
         4'd5:    d = 9'd120;
         4'd6:    d = 9'd151;
         4'd7:    d = 9'd181;
         4'd8:    d = 9'd212;
         4'd9:    d = 9'd243;
         4'd10:   d = 9'd273;
         4'd11:   d = 9'd304;
         4'd12:   d = 9'd334;
         default: d = 9'd0;
      endcase
      return d;
   endfunction

   // Length of month m (1..12)
   function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
      logic [4:0] d;
      case (m)
         4'd2:                      d = leap ? 5'd29 : 5'd28;
         4'd4, 4'd6, 4'd9, 4'd11:   d = 5'd30;
         default:                   d = 5'd31;
      endcase
      return d;
   endfunction

   // Registers
   logic [OP_W-1:0]           op_ff, op_in;
   logic [DAY_W-1:0]          gd_ff, gd_in;
   logic [MONTH_W-1:0]        gm_ff, gm_in;
   logic [YEAR_W-1:0]         gy_ff, gy_in;
   logic signed [DELTA_W-1:0] delta_ff, delta_in;
   logic [DAY_W-1:0]          cur_day_ff, cur_day_in;
   logic [MONTH_W-1:0]        cur_month_ff, cur_month_in;
   logic [YEAR_W-1:0]         cur_year_ff, cur_year_in;
   logic [ACC_W-1:0]          acc_ff, acc_in;
   logic [ACC_W-1:0]          b_ff, b_in;
   logic [N_W-1:0]            n_ff, n_in;
   logic [Q_W-1:0]            q_ff, q_in;
   logic [2:0]                bit_idx_ff, bit_idx_in;
   logic [1:0]                c_ff, c_in;
   logic [4:0]                g_ff, g_in;
   logic [1:0]                yi_ff, yi_in;
   logic [MONTH_W-1:0]        m_ff, m_in;
   logic                      clip_ff, clip_in;
   logic [DAY_W-1:0]          o_day_ff, o_day_in;
   logic [MONTH_W-1:0]        o_month_ff, o_month_in;
   logic [YEAR_W-1:0]         o_year_ff, o_year_in;
   logic [SERIAL_W-1:0]       o_serial_ff, o_serial_in;
   logic [DIFF_W-1:0]         o_diff_ff, o_diff_in;
   logic                      o_less_ff, o_less_in;
   logic                      o_greater_ff, o_greater_in;
   logic                      o_equal_ff, o_equal_in;
   logic                      o_clip_ff, o_clip_in;

   // Serial conversion operand
   logic [YEAR_W-1:0]  sy;
   logic [MONTH_W-1:0] sm, mc;
   logic [DAY_W-1:0]   sd;
   logic [14:0]        y_p3, y_p99, y_p399;
   logic [8:0]         d100, d400, qk;
   logic               leap_s;
   logic [ACC_W-1:0]   ser1, ser2, ser3, ser4;

   // Date reconstruction
   logic signed [T_W-1:0] t_sum, t_clamp, t_minus;
   logic                  t_low, t_high;
   logic [N_W-1:0]        cyc_cand, grp_cand;
   logic [N_W-1:0]        clen, glen, ylen, mlen;
   logic                  leap_r;
   logic [YACC_W-1:0]     yr;
   logic [ACC_W:0]        dfull;

   // Select the date under conversion
   assign sy = cmd.src_given ? gy_ff : cur_year_ff;
   assign sm = cmd.src_given ? gm_ff : cur_month_ff;
   assign sd = cmd.src_given ? gd_ff : cur_day_ff;
   assign mc = (sm == '0) ? 4'd1 : ((sm > 4'd12) ? 4'd12 : sm);

   // Days before the year: 365y + ceil(y/4) - ceil(y/100) + ceil(y/400), split over steps
   assign y_p3   = {1'b0, sy} + 15'd3;
   assign y_p99  = {1'b0, sy} + 15'd99;
   assign y_p399 = {1'b0, sy} + 15'd399;
   assign d100   = div25(y_p99[14:2]);
   assign d400   = div25({2'b00, y_p399[14:4]});
   assign qk     = div25({1'b0, sy[13:2]});
   assign leap_s = (sy[1:0] == 2'b00)
                   && ((13'(qk) * 13'd25 != {1'b0, sy[13:2]}) || (qk[1:0] == 2'b00));

   assign ser1 = ACC_W'(sy) * ACC_W'(365) + ACC_W'(y_p3[14:2]) + ACC_W'(sd);
   assign ser2 = acc_ff - ACC_W'(d100);
   assign ser3 = acc_ff + ACC_W'(d400);
   assign ser4 = acc_ff + ACC_W'(days_before_month(mc))
                 + ACC_W'((leap_s && (mc > 4'd2)) ? 1'b1 : 1'b0);

   // Shifted serial, saturated to the representable range
   assign t_sum   = $signed({{(T_W-ACC_W){1'b0}}, acc_ff}) + T_W'(delta_ff);
   assign t_low   = t_sum[T_W-1] || (t_sum == '0);
   assign t_high  = !t_low && (t_sum > TOP_SERIAL);
   assign t_clamp = t_low ? T_W'(1) : (t_high ? TOP_SERIAL : t_sum);
   assign t_minus = t_clamp - T_W'(1);

   // Period lengths for the reconstruction steps
   assign cyc_cand = N_W'(CYCLE_DAYS) << bit_idx_ff;
   assign grp_cand = N_W'(1461) << bit_idx_ff;
   assign clen     = (c_ff == 2'd0) ? N_W'(36525) : N_W'(36524);
   assign glen     = (c_ff == 2'd0) ? N_W'(1461) : N_W'(1460);
   assign leap_r   = (yi_ff == 2'd0) && !((g_ff == 5'd0) && (c_ff != 2'd0));
   assign ylen     = leap_r ? N_W'(366) : N_W'(365);
   assign mlen     = N_W'(month_len(m_ff, leap_r));
   assign yr       = YACC_W'(q_ff) * YACC_W'(400) + YACC_W'(c_ff) * YACC_W'(100)
                     + YACC_W'(g_ff) * YACC_W'(4) + YACC_W'(yi_ff);
   assign dfull    = {1'b0, acc_ff} - {1'b0, b_ff};

   // Status for the controller
   assign status.op        = op_ff;
   assign status.bit_last  = (bit_idx_ff == 3'd0);
   assign status.cent_fit  = (c_ff != 2'd3) && (n_ff >= clen);
   assign status.year_fit  = (yi_ff != 2'd3) && (n_ff >= ylen);
   assign status.month_fit = (m_ff < 4'd12) && (n_ff >= mlen);

   // Next-state logic per command
   always_comb begin
      op_in        = op_ff;
      gd_in        = gd_ff;
      gm_in        = gm_ff;
      gy_in        = gy_ff;
      delta_in     = delta_ff;
      cur_day_in   = cur_day_ff;
      cur_month_in = cur_month_ff;
      cur_year_in  = cur_year_ff;
      acc_in       = acc_ff;
      b_in         = b_ff;
      n_in         = n_ff;
      q_in         = q_ff;
      bit_idx_in   = bit_idx_ff;
      c_in         = c_ff;
      g_in         = g_ff;
      yi_in        = yi_ff;
      m_in         = m_ff;
      clip_in      = clip_ff;
      o_day_in     = o_day_ff;
      o_month_in   = o_month_ff;
      o_year_in    = o_year_ff;
      o_serial_in  = o_serial_ff;
      o_diff_in    = o_diff_ff;
      o_less_in    = o_less_ff;
      o_greater_in = o_greater_ff;
      o_equal_in   = o_equal_ff;
      o_clip_in    = o_clip_ff;
      unique case (cmd.code)
         CMD_CAPTURE: begin
            op_in    = req_op;
            gd_in    = req_day;
            gm_in    = req_month;
            gy_in    = req_year;
            delta_in = req_delta;
            clip_in  = 1'b0;
         end
         CMD_LOAD: begin
            cur_day_in   = gd_ff;
            cur_month_in = gm_ff;
            cur_year_in  = gy_ff;
         end
         CMD_SER1:   acc_in = ser1;
         CMD_SER2:   acc_in = ser2;
         CMD_SER3:   acc_in = ser3;
         CMD_SER4:   acc_in = ser4;
         CMD_SAVE_B: b_in = acc_ff;
         CMD_CLAMP: begin
            n_in       = t_minus[N_W-1:0];
            clip_in    = t_low || t_high;
            q_in       = '0;
            bit_idx_in = 3'd7;
            c_in       = '0;
            g_in       = '0;
            yi_in      = '0;
            m_in       = 4'd1;
         end
         // Restoring division by the 400-year cycle, one quotient bit a step
         CMD_DIV400: begin
            if (n_ff >= cyc_cand) begin
               n_in             = n_ff - cyc_cand;
               q_in[bit_idx_ff] = 1'b1;
            end
            bit_idx_in = bit_idx_ff - 3'd1;
         end
         CMD_CENT: begin
            if (status.cent_fit) begin
               n_in = n_ff - clen;
               c_in = c_ff + 2'd1;
            end
         end
         // First 4-year group of a century may be a day short
         CMD_GFIRST: begin
            if (n_ff >= glen) begin
               n_in = n_ff - glen;
               g_in = 5'd1;
            end
            bit_idx_in = 3'd4;
         end
         CMD_GDIV: begin
            if (n_ff >= grp_cand) begin
               n_in = n_ff - grp_cand;
               g_in = g_ff + (5'd1 << bit_idx_ff);
            end
            bit_idx_in = bit_idx_ff - 3'd1;
         end
         CMD_YEAR: begin
            if (status.year_fit) begin
               n_in  = n_ff - ylen;
               yi_in = yi_ff + 2'd1;
            end
         end
         CMD_MONTH: begin
            if (status.month_fit) begin
               n_in = n_ff - mlen;
               m_in = m_ff + 4'd1;
            end
         end
         CMD_STORE: begin
            cur_year_in  = yr[YEAR_W-1:0];
            cur_month_in = m_ff;
            cur_day_in   = n_ff[DAY_W-1:0] + 5'd1;
         end
         CMD_OUTLOAD: begin
            o_day_in     = cur_day_ff;
            o_month_in   = cur_month_ff;
            o_year_in    = cur_year_ff;
            o_serial_in  = acc_ff[SERIAL_W-1:0];
            o_diff_in    = (op_ff == OP_COMPARE) ? dfull[DIFF_W-1:0] : '0;
            o_less_in    = (op_ff == OP_COMPARE) && (acc_ff < b_ff);
            o_greater_in = (op_ff == OP_COMPARE) && (acc_ff > b_ff);
            o_equal_in   = (op_ff == OP_COMPARE) && (cur_day_ff == gd_ff)
                           && (cur_month_ff == gm_ff) && (cur_year_ff == gy_ff);
            o_clip_in    = (op_ff == OP_SHIFT) && clip_ff;
         end
         default: begin
         end
      endcase
   end

   // Hold the current date under reset; working and response registers need none
   always_ff @(posedge clock) begin
      if (reset) begin
         cur_day_ff   <= 5'd1;
         cur_month_ff <= 4'd1;
         cur_year_ff  <= '0;
      end else begin
         cur_day_ff   <= cur_day_in;
         cur_month_ff <= cur_month_in;
         cur_year_ff  <= cur_year_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff        <= op_in;
      gd_ff        <= gd_in;
      gm_ff        <= gm_in;
      gy_ff        <= gy_in;
      delta_ff     <= delta_in;
      acc_ff       <= acc_in;
      b_ff         <= b_in;
      n_ff         <= n_in;
      q_ff         <= q_in;
      bit_idx_ff   <= bit_idx_in;
      c_ff         <= c_in;
      g_ff         <= g_in;
      yi_ff        <= yi_in;
      m_ff         <= m_in;
      clip_ff      <= clip_in;
      o_day_ff     <= o_day_in;
      o_month_ff   <= o_month_in;
      o_year_ff    <= o_year_in;
      o_serial_ff  <= o_serial_in;
      o_diff_ff    <= o_diff_in;
      o_less_ff    <= o_less_in;
      o_greater_ff <= o_greater_in;
      o_equal_ff   <= o_equal_in;
      o_clip_ff    <= o_clip_in;
   end

   assign rsp_day     = o_day_ff;
   assign rsp_month   = o_month_ff;
   assign rsp_year    = o_year_ff;
   assign rsp_serial  = o_serial_ff;
   assign rsp_diff    = $signed(o_diff_ff);
   assign rsp_less    = o_less_ff;
   assign rsp_greater = o_greater_ff;
   assign rsp_equal   = o_equal_ff;
   assign rsp_clipped = o_clip_ff;

endmodule

// ----- src/gdda_ctrl.sv -----
// Controller: sequences serial conversion, shift and date reconstruction, owns the handshakes.
module gdda_ctrl import gdda_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   input  gdda_status_type status,
   output gdda_cmd_type    cmd
);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DISPATCH,
      ST_SER1,
      ST_SER2,
      ST_SER3,
      ST_SER4,
      ST_SAVE_B,
      ST_CLAMP,
      ST_DIV400,
      ST_CENT,
      ST_GFIRST,
      ST_GDIV,
      ST_YEAR,
      ST_MONTH,
      ST_STORE,
      ST_FINISH
   } state_type;

   // Which date a serial conversion pass works on, and what follows it
   typedef enum logic [1:0] {
      PASS_GIVEN,
      PASS_SHIFT,
      PASS_FINAL
   } pass_type;

   state_type state_ff, state_in;
   pass_type  pass_ff, pass_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in      = state_ff;
      pass_in       = pass_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      cmd.code      = CMD_NOP;
      cmd.src_given = (pass_ff == PASS_GIVEN);
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.code = CMD_CAPTURE;
               state_in = ST_DISPATCH;
            end
         end
         ST_DISPATCH: begin
            state_in = ST_SER1;
            unique case (status.op)
               OP_LOAD: begin
                  cmd.code = CMD_LOAD;
                  pass_in  = PASS_FINAL;
               end
               OP_SHIFT:   pass_in = PASS_SHIFT;
               OP_COMPARE: pass_in = PASS_GIVEN;
               default:    pass_in = PASS_FINAL;
            endcase
         end
         ST_SER1: begin
            cmd.code = CMD_SER1;
            state_in = ST_SER2;
         end
         ST_SER2: begin
            cmd.code = CMD_SER2;
            state_in = ST_SER3;
         end
         ST_SER3: begin
            cmd.code = CMD_SER3;
            state_in = ST_SER4;
         end
         ST_SER4: begin
            cmd.code = CMD_SER4;
            unique case (pass_ff)
               PASS_GIVEN: state_in = ST_SAVE_B;
               PASS_SHIFT: state_in = ST_CLAMP;
               default:    state_in = ST_FINISH;
            endcase
         end
         ST_SAVE_B: begin
            cmd.code = CMD_SAVE_B;
            pass_in  = PASS_FINAL;
            state_in = ST_SER1;
         end
         ST_CLAMP: begin
            cmd.code = CMD_CLAMP;
            state_in = ST_DIV400;
         end
         ST_DIV400: begin
            cmd.code = CMD_DIV400;
            if (status.bit_last) begin
               state_in = ST_CENT;
            end
         end
         // Loop while another period fits, move on once it does not
         ST_CENT: begin
            cmd.code = CMD_CENT;
            if (!status.cent_fit) begin
               state_in = ST_GFIRST;
            end
         end
         ST_GFIRST: begin
            cmd.code = CMD_GFIRST;
            state_in = ST_GDIV;
         end
         ST_GDIV: begin
            cmd.code = CMD_GDIV;
            if (status.bit_last) begin
               state_in = ST_YEAR;
            end
         end
         ST_YEAR: begin
            cmd.code = CMD_YEAR;
            if (!status.year_fit) begin
               state_in = ST_MONTH;
            end
         end
         ST_MONTH: begin
            cmd.code = CMD_MONTH;
            if (!status.month_fit) begin
               state_in = ST_STORE;
            end
         end
         ST_STORE: begin
            cmd.code = CMD_STORE;
            pass_in  = PASS_FINAL;
            state_in = ST_SER1;
         end
         // Load the response register once the previous transaction has left
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.code     = CMD_OUTLOAD;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pass_ff      <= PASS_FINAL;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pass_ff      <= pass_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule
